// ===== design/wav_pcm16_downmix_parser_macros.svh =====
// ---------------------------------------------------------------------------
// WAV parser assertion macros
// Shared property wrappers that sample on clk and report through $error.
// ---------------------------------------------------------------------------
`ifndef WAV_PCM16_DOWNMIX_PARSER_MACROS_SVH
`define WAV_PCM16_DOWNMIX_PARSER_MACROS_SVH

// Checked only while rst_n is high.
`define WPD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every edge, reset cycles included.
`define WPD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== design/wpd_pkg.sv =====
// ---------------------------------------------------------------------------
// WAV parser package
// Word types of the byte and result channels and the result kind codes.
// ---------------------------------------------------------------------------
`default_nettype none

package wpd_pkg;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_file;
  } in_word_t;

  typedef struct packed {
    logic signed [16:0] mono_sample;
    logic [2:0]         kind;
    logic               last;
  } out_word_t;

  localparam logic [2:0] KIND_SAMPLE = 3'd0;
  localparam logic [2:0] KIND_OK     = 3'd1;
  localparam logic [2:0] KIND_MAGIC  = 3'd2;
  localparam logic [2:0] KIND_FORMAT = 3'd3;
  localparam logic [2:0] KIND_NODATA = 3'd4;

endpackage

`default_nettype wire

// ===== design/wav_pcm16_downmix_parser.sv =====
// ---------------------------------------------------------------------------
// WAV PCM16 parser with mono downmix
// Flow: an accepted byte goes into the input register, then the parser, then the result queue.
// Throughput: one byte per cycle while the four-word result queue holds two words or fewer.
// Reset: synchronous rst_n clears the parser and queue, rate returns to 16000.
// ---------------------------------------------------------------------------
`default_nettype none

module wav_pcm16_downmix_parser (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire wpd_pkg::in_word_t in_data,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output wpd_pkg::out_word_t    out_data,
  input  wire logic             cfg_valid,
  output logic                  cfg_ready,
  input  wire logic [31:0]      cfg_data
);
  import wpd_pkg::*;

  localparam logic [2:0] PH_MAGIC = 3'd0;
  localparam logic [2:0] PH_HDR   = 3'd1;
  localparam logic [2:0] PH_FMT   = 3'd2;
  localparam logic [2:0] PH_SKIP  = 3'd3;
  localparam logic [2:0] PH_PAD   = 3'd4;
  localparam logic [2:0] PH_DATA  = 3'd5;
  localparam logic [2:0] PH_DONE  = 3'd6;
  localparam logic [2:0] PH_DEAD  = 3'd7;

  localparam logic [31:0] TAG_RIFF   = 32'h5249_4646;
  localparam logic [31:0] TAG_WAVE   = 32'h5741_5645;
  localparam logic [31:0] TAG_FMT    = 32'h666D_7420;
  localparam logic [31:0] TAG_DATA   = 32'h6461_7461;
  localparam logic [31:0] RATE_RESET = 32'd16000;
  localparam logic [4:0]  FMT_MIN    = 5'd16;
  localparam logic [15:0] FMT_PCM    = 16'd1;
  localparam logic [15:0] BITS_16    = 16'd16;

  // Configuration.
  logic [31:0] required_rate_r;

  // Input register.
  logic     stg_valid_r;
  in_word_t stg_r;
  logic     stg_go;

  // Parser state.
  logic [2:0]         phase_r, phase_nxt;
  logic [4:0]         byte_count_r, byte_count_nxt;
  logic [31:0]        chunk_tag_r, chunk_tag_nxt;
  logic [31:0]        chunk_length_r, chunk_length_nxt;
  logic [31:0]        bytes_left_r, bytes_left_nxt;
  logic [15:0]        format_code_r, format_code_nxt;
  logic [15:0]        channel_count_r, channel_count_nxt;
  logic [31:0]        rate_seen_r, rate_seen_nxt;
  logic [15:0]        sample_bits_r, sample_bits_nxt;
  logic signed [15:0] frame_sum_r, frame_sum_nxt;
  logic [7:0]         low_byte_r, low_byte_nxt;
  logic               channel_index_r, channel_index_nxt;
  logic [2:0]         failed_r, failed_nxt;

  // Result queue.
  out_word_t  fifo_r [4];
  logic [1:0] wr_ptr_r, rd_ptr_r;
  logic [2:0] count_r;
  logic       pop;
  logic [1:0] n_push;
  out_word_t  res0, res1;

  // Per-byte combinational values.
  logic [7:0]         b;
  logic [31:0]        b_ext;
  logic [4:0]         b_shift;
  logic [31:0]        tag_shift;
  logic [31:0]        hdr_len;
  logic [31:0]        left_dec;
  logic signed [15:0] v;
  logic signed [16:0] sample;
  logic               emit;
  logic [2:0]         status_kind;

  assign cfg_ready = 1'b1;
  // The queue must have room for the two words a final byte can produce.
  assign stg_go    = stg_valid_r && (count_r <= 3'd2);
  assign in_ready  = !stg_valid_r || stg_go;
  assign out_valid = (count_r != 3'd0);
  assign out_data  = fifo_r[rd_ptr_r];
  assign pop       = out_valid && out_ready;

  assign b         = stg_r.in_byte;
  assign b_ext     = {24'd0, b};
  assign b_shift   = {byte_count_r[1:0], 3'b000};
  assign tag_shift = {chunk_tag_r[23:0], b};
  assign left_dec  = bytes_left_r - 32'd1;
  assign v         = $signed({b, low_byte_r});

  always_comb begin
    hdr_len = (byte_count_r == 5'd0) ? 32'd0 : chunk_length_r;
    if (byte_count_r >= 5'd4) begin
      hdr_len = hdr_len | (b_ext << b_shift);
    end
  end

  always_comb begin
    phase_nxt         = phase_r;
    byte_count_nxt    = byte_count_r;
    chunk_tag_nxt     = chunk_tag_r;
    chunk_length_nxt  = chunk_length_r;
    bytes_left_nxt    = bytes_left_r;
    format_code_nxt   = format_code_r;
    channel_count_nxt = channel_count_r;
    rate_seen_nxt     = rate_seen_r;
    sample_bits_nxt   = sample_bits_r;
    frame_sum_nxt     = frame_sum_r;
    low_byte_nxt      = low_byte_r;
    channel_index_nxt = channel_index_r;
    failed_nxt        = failed_r;
    emit              = 1'b0;
    sample            = '0;
    status_kind       = KIND_NODATA;

    if (stg_go) begin
      unique case (phase_r)
        PH_MAGIC: begin
          chunk_tag_nxt = tag_shift;
          if (byte_count_r == 5'd3 && tag_shift != TAG_RIFF) begin
            failed_nxt = KIND_MAGIC;
            phase_nxt  = PH_DEAD;
          end else if (byte_count_r == 5'd11) begin
            if (tag_shift != TAG_WAVE) begin
              failed_nxt = KIND_MAGIC;
              phase_nxt  = PH_DEAD;
            end else begin
              phase_nxt      = PH_HDR;
              byte_count_nxt = 5'd0;
            end
          end else begin
            byte_count_nxt = byte_count_r + 5'd1;
          end
        end
        PH_HDR: begin
          if (byte_count_r < 5'd4) begin
            chunk_tag_nxt = tag_shift;
          end
          chunk_length_nxt = hdr_len;
          if (byte_count_r == 5'd7) begin
            byte_count_nxt = 5'd0;
            if (chunk_tag_r == TAG_FMT) begin
              if (hdr_len < {27'd0, FMT_MIN}) begin
                failed_nxt = KIND_FORMAT;
                phase_nxt  = PH_DEAD;
              end else begin
                format_code_nxt   = '0;
                channel_count_nxt = '0;
                rate_seen_nxt     = '0;
                sample_bits_nxt   = '0;
                bytes_left_nxt    = hdr_len;
                phase_nxt         = PH_FMT;
              end
            end else if (chunk_tag_r == TAG_DATA) begin
              if (format_code_r != FMT_PCM || sample_bits_r != BITS_16 ||
                  rate_seen_r != required_rate_r ||
                  (channel_count_r != 16'd1 && channel_count_r != 16'd2)) begin
                failed_nxt = KIND_FORMAT;
                phase_nxt  = PH_DEAD;
              end else begin
                bytes_left_nxt    = hdr_len;
                channel_index_nxt = 1'b0;
                frame_sum_nxt     = '0;
                phase_nxt         = (hdr_len == 32'd0) ? PH_DONE : PH_DATA;
              end
            end else begin
              bytes_left_nxt = hdr_len;
              // An empty chunk has even size, so no pad byte follows it.
              phase_nxt = (hdr_len == 32'd0) ? PH_HDR : PH_SKIP;
            end
          end else begin
            byte_count_nxt = byte_count_r + 5'd1;
          end
        end
        PH_FMT: begin
          if (byte_count_r < 5'd2) begin
            format_code_nxt = format_code_r | (b_ext[15:0] << b_shift[3:0]);
          end else if (byte_count_r < 5'd4) begin
            channel_count_nxt = channel_count_r | (b_ext[15:0] << b_shift[3:0]);
          end else if (byte_count_r < 5'd8) begin
            rate_seen_nxt = rate_seen_r | (b_ext << b_shift);
          end else if (byte_count_r == 5'd14 || byte_count_r == 5'd15) begin
            sample_bits_nxt = sample_bits_r | (b_ext[15:0] << b_shift[3:0]);
          end
          if (byte_count_r < FMT_MIN) begin
            byte_count_nxt = byte_count_r + 5'd1;
          end
          bytes_left_nxt = left_dec;
          if (left_dec == 32'd0) begin
            phase_nxt      = chunk_length_r[0] ? PH_PAD : PH_HDR;
            byte_count_nxt = 5'd0;
          end
        end
        PH_SKIP: begin
          bytes_left_nxt = left_dec;
          if (left_dec == 32'd0) begin
            phase_nxt      = chunk_length_r[0] ? PH_PAD : PH_HDR;
            byte_count_nxt = 5'd0;
          end
        end
        PH_PAD: begin
          phase_nxt      = PH_HDR;
          byte_count_nxt = 5'd0;
        end
        PH_DATA: begin
          // Bytes consumed so far are even when this byte is a low half.
          if ((chunk_length_r[0] ^ bytes_left_r[0]) == 1'b0) begin
            low_byte_nxt = b;
          end else if (channel_count_r == 16'd1) begin
            sample = {v, 1'b0};
            emit   = 1'b1;
          end else if (!channel_index_r) begin
            frame_sum_nxt     = v;
            channel_index_nxt = 1'b1;
          end else begin
            sample            = {frame_sum_r[15], frame_sum_r} + {v[15], v};
            channel_index_nxt = 1'b0;
            emit              = 1'b1;
          end
          bytes_left_nxt = left_dec;
          if (left_dec == 32'd0) begin
            phase_nxt = PH_DONE;
          end
        end
        default: begin
        end
      endcase

      if (stg_r.end_of_file) begin
        if (failed_nxt != 3'd0) begin
          status_kind = failed_nxt;
        end else if (phase_nxt == PH_DATA || phase_nxt == PH_DONE) begin
          status_kind = KIND_OK;
        end else if (phase_nxt == PH_MAGIC) begin
          status_kind = KIND_MAGIC;
        end else begin
          status_kind = KIND_NODATA;
        end
        phase_nxt         = PH_MAGIC;
        byte_count_nxt    = '0;
        chunk_tag_nxt     = '0;
        chunk_length_nxt  = '0;
        bytes_left_nxt    = '0;
        format_code_nxt   = '0;
        channel_count_nxt = '0;
        rate_seen_nxt     = '0;
        sample_bits_nxt   = '0;
        frame_sum_nxt     = '0;
        low_byte_nxt      = '0;
        channel_index_nxt = 1'b0;
        failed_nxt        = '0;
      end
    end
  end

  // A sample, if any, goes first and the end-of-file status follows it.
  always_comb begin
    res1.mono_sample = '0;
    res1.kind        = status_kind;
    res1.last        = 1'b1;
    if (emit) begin
      res0.mono_sample = sample;
      res0.kind        = KIND_SAMPLE;
      res0.last        = 1'b0;
    end else begin
      res0 = res1;
    end
    if (!stg_go) begin
      n_push = 2'd0;
    end else begin
      n_push = {1'b0, emit} + {1'b0, stg_r.end_of_file};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      required_rate_r <= RATE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      required_rate_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_valid_r <= 1'b0;
    end else if (in_ready) begin
      stg_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      stg_r <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r         <= PH_MAGIC;
      byte_count_r    <= '0;
      chunk_tag_r     <= '0;
      chunk_length_r  <= '0;
      bytes_left_r    <= '0;
      format_code_r   <= '0;
      channel_count_r <= '0;
      rate_seen_r     <= '0;
      sample_bits_r   <= '0;
      frame_sum_r     <= '0;
      low_byte_r      <= '0;
      channel_index_r <= 1'b0;
      failed_r        <= '0;
    end else begin
      phase_r         <= phase_nxt;
      byte_count_r    <= byte_count_nxt;
      chunk_tag_r     <= chunk_tag_nxt;
      chunk_length_r  <= chunk_length_nxt;
      bytes_left_r    <= bytes_left_nxt;
      format_code_r   <= format_code_nxt;
      channel_count_r <= channel_count_nxt;
      rate_seen_r     <= rate_seen_nxt;
      sample_bits_r   <= sample_bits_nxt;
      frame_sum_r     <= frame_sum_nxt;
      low_byte_r      <= low_byte_nxt;
      channel_index_r <= channel_index_nxt;
      failed_r        <= failed_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (n_push != 2'd0) begin
      fifo_r[wr_ptr_r] <= res0;
    end
    if (n_push == 2'd2) begin
      fifo_r[wr_ptr_r + 2'd1] <= res1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_r + n_push;
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 2'd1;
      end
      count_r <= count_r + {1'b0, n_push} - {2'b00, pop};
    end
  end

endmodule

`default_nettype wire

// ===== design/wpd_checker.sv =====
// ---------------------------------------------------------------------------
// WAV parser port checker
// Watches the top level's ports and flags result words that break the rules.
// ---------------------------------------------------------------------------
`default_nettype none

`include "wav_pcm16_downmix_parser_macros.svh"

module wpd_checker (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               in_valid,
  input wire logic               in_ready,
  input wire wpd_pkg::in_word_t  in_data,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire wpd_pkg::out_word_t out_data,
  input wire logic               cfg_valid,
  input wire logic               cfg_ready,
  input wire logic [31:0]        cfg_data
);
  import wpd_pkg::*;

  logic unused_ok;
  assign unused_ok = ^{in_valid, in_ready, in_data, cfg_valid, cfg_ready, cfg_data};

  `WPD_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_data), "result word changed while stalled")
  `WPD_ASSERT(a_sample_not_last, out_valid && out_data.kind == KIND_SAMPLE |-> !out_data.last, "sample word marked last")
  `WPD_ASSERT(a_status_form, out_valid && out_data.kind != KIND_SAMPLE |-> out_data.last && out_data.mono_sample == 17'sd0, "status word malformed")
  `WPD_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> !out_valid, "result word right after reset")

endmodule

bind wav_pcm16_downmix_parser wpd_checker u_wpd_checker (.*);

`default_nettype wire
